// ----- design/ugpb_pkg.sv -----
// Shared constants, codes and types for the uniform grid particle binning unit.
// Used by the channel interfaces, the controller, the datapath and the top level.
package ugpb_pkg;

  localparam int CELL_COUNT = 4096;
  localparam int SLOTS      = 16;
  localparam int ID_BITS    = 16;

  localparam int CELL_W = $clog2(CELL_COUNT);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam int OP_W       = 2;
  localparam int POS_W      = 32;
  localparam int PID_W      = 16;
  localparam int SEL_W      = 4;
  localparam int CELL_NUM_W = 12;
  localparam int COUNT_W    = 5;
  localparam int SLOTV_W    = 16;
  localparam int STATUS_W   = 2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIM_W      = 7;
  localparam int IDX_W      = 2 * DIM_W;
  localparam int PROD_W     = 2 * POS_W;

  localparam logic [OP_W-1:0] OP_REGISTER   = 2'd0;
  localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR      = 2'd2;
  localparam logic [OP_W-1:0] OP_READ       = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOR       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS       = 3'd4;

  localparam logic [POS_W-1:0] INV_CELL_RESET = 32'd65536;
  localparam logic [DIM_W-1:0] DIM_RESET      = 7'd64;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DIFFX,
    S_MULX,
    S_MULY,
    S_TAKEY,
    S_CELL,
    S_CNT,
    S_DISPATCH,
    S_RDSLOT,
    S_SCAN,
    S_MOVE,
    S_CLEAR,
    S_DONE
  } ugpb_state_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_BAD,
    RES_CLEAR,
    RES_REG,
    RES_READ,
    RES_NF,
    RES_UNREG
  } ugpb_res_t;

  typedef struct packed {
    logic      load_in;
    logic      diff_x;
    logic      diff_y;
    logic      mul;
    logic      take_x;
    logic      take_y;
    logic      cell_calc;
    logic      reg_wr;
    logic      scan_start;
    logic      scan_step;
    logic      last_rd;
    logic      move_wr;
    logic      sweep;
    ugpb_res_t res;
    logic      out_load;
  } ugpb_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            bad;
    logic            scan_hit;
    logic            scan_done;
    logic            sweep_last;
  } ugpb_stat_t;

endpackage

// ----- design/ugpb_in_if.sv -----
// Request channel of the binning unit: valid/ready handshake plus request fields.
// Depends on ugpb_pkg for field widths.
interface ugpb_in_if;
  logic                               valid;
  logic                               ready;
  logic [ugpb_pkg::OP_W-1:0]          operation;
  logic signed [ugpb_pkg::POS_W-1:0]  pos_x;
  logic signed [ugpb_pkg::POS_W-1:0]  pos_y;
  logic [ugpb_pkg::PID_W-1:0]         particle_id;
  logic [ugpb_pkg::SEL_W-1:0]         slot_sel;

  modport source (output valid, operation, pos_x, pos_y, particle_id, slot_sel, input ready);
  modport sink   (input valid, operation, pos_x, pos_y, particle_id, slot_sel, output ready);
endinterface

// ----- design/ugpb_out_if.sv -----
// Result channel of the binning unit: valid/ready handshake plus result fields.
// Depends on ugpb_pkg for field widths.
interface ugpb_out_if;
  logic                               valid;
  logic                               ready;
  logic [ugpb_pkg::CELL_NUM_W-1:0]    cell_number;
  logic [ugpb_pkg::COUNT_W-1:0]       cell_count;
  logic [ugpb_pkg::SLOTV_W-1:0]       slot_value;
  logic [ugpb_pkg::STATUS_W-1:0]      status;

  modport source (output valid, cell_number, cell_count, slot_value, status, input ready);
  modport sink   (input valid, cell_number, cell_count, slot_value, status, output ready);
endinterface

// ----- design/ugpb_ctrl.sv -----
// Controller state machine of the binning unit: sequences one request at a time.
// Drives ugpb_pkg::ugpb_cmd_t to the datapath and reads ugpb_pkg::ugpb_stat_t back.
module ugpb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ugpb_pkg::ugpb_stat_t stat,
  output ugpb_pkg::ugpb_cmd_t  cmd
);

  ugpb_pkg::ugpb_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ugpb_pkg::S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ugpb_pkg::S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ugpb_pkg::S_INIT: begin
        if (stat.sweep_last) state_nxt = ugpb_pkg::S_IDLE;
      end
      ugpb_pkg::S_IDLE: begin
        if (in_valid) state_nxt = ugpb_pkg::S_DIFFX;
      end
      ugpb_pkg::S_DIFFX: begin
        if (stat.op == ugpb_pkg::OP_CLEAR) state_nxt = ugpb_pkg::S_CLEAR;
        else state_nxt = ugpb_pkg::S_MULX;
      end
      ugpb_pkg::S_MULX:  state_nxt = ugpb_pkg::S_MULY;
      ugpb_pkg::S_MULY:  state_nxt = ugpb_pkg::S_TAKEY;
      ugpb_pkg::S_TAKEY: state_nxt = ugpb_pkg::S_CELL;
      ugpb_pkg::S_CELL:  state_nxt = ugpb_pkg::S_CNT;
      ugpb_pkg::S_CNT: begin
        if (stat.bad) state_nxt = ugpb_pkg::S_DONE;
        else state_nxt = ugpb_pkg::S_DISPATCH;
      end
      ugpb_pkg::S_DISPATCH: begin
        case (stat.op)
          ugpb_pkg::OP_UNREGISTER: state_nxt = ugpb_pkg::S_SCAN;
          ugpb_pkg::OP_READ:       state_nxt = ugpb_pkg::S_RDSLOT;
          default:                 state_nxt = ugpb_pkg::S_DONE;
        endcase
      end
      ugpb_pkg::S_RDSLOT: state_nxt = ugpb_pkg::S_DONE;
      ugpb_pkg::S_SCAN: begin
        if (stat.scan_hit) state_nxt = ugpb_pkg::S_MOVE;
        else if (stat.scan_done) state_nxt = ugpb_pkg::S_DONE;
      end
      ugpb_pkg::S_MOVE: state_nxt = ugpb_pkg::S_DONE;
      ugpb_pkg::S_CLEAR: begin
        if (stat.sweep_last) state_nxt = ugpb_pkg::S_DONE;
      end
      ugpb_pkg::S_DONE: begin
        if (out_free) state_nxt = ugpb_pkg::S_IDLE;
      end
      default: state_nxt = ugpb_pkg::S_INIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ugpb_pkg::S_INIT:  cmd.sweep = 1'b1;
      ugpb_pkg::S_IDLE:  cmd.load_in = in_valid;
      ugpb_pkg::S_DIFFX: cmd.diff_x = 1'b1;
      ugpb_pkg::S_MULX: begin
        cmd.diff_y = 1'b1;
        cmd.mul    = 1'b1;
      end
      ugpb_pkg::S_MULY: begin
        cmd.mul    = 1'b1;
        cmd.take_x = 1'b1;
      end
      ugpb_pkg::S_TAKEY: cmd.take_y = 1'b1;
      ugpb_pkg::S_CELL:  cmd.cell_calc = 1'b1;
      ugpb_pkg::S_CNT: begin
        cmd.scan_start = 1'b1;
        if (stat.bad) cmd.res = ugpb_pkg::RES_BAD;
      end
      ugpb_pkg::S_DISPATCH: begin
        case (stat.op)
          ugpb_pkg::OP_REGISTER: begin
            cmd.reg_wr = 1'b1;
            cmd.res    = ugpb_pkg::RES_REG;
          end
          ugpb_pkg::OP_UNREGISTER: cmd.scan_step = 1'b1;
          default: ;
        endcase
      end
      ugpb_pkg::S_RDSLOT: cmd.res = ugpb_pkg::RES_READ;
      ugpb_pkg::S_SCAN: begin
        if (stat.scan_hit) cmd.last_rd = 1'b1;
        else if (stat.scan_done) cmd.res = ugpb_pkg::RES_NF;
        else cmd.scan_step = 1'b1;
      end
      ugpb_pkg::S_MOVE: begin
        cmd.move_wr = 1'b1;
        cmd.res     = ugpb_pkg::RES_UNREG;
      end
      ugpb_pkg::S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) cmd.res = ugpb_pkg::RES_CLEAR;
      end
      ugpb_pkg::S_DONE: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

endmodule

// ----- design/ugpb_dp.sv -----
// Datapath of the binning unit: configuration registers, cell coordinate
// arithmetic, count and slot memories, scan logic and result registers.
// Depends on ugpb_pkg; driven by ugpb_ctrl through ugpb_cmd_t.
module ugpb_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ugpb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ugpb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [ugpb_pkg::OP_W-1:0]           in_operation,
  input  logic signed [ugpb_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [ugpb_pkg::POS_W-1:0]   in_pos_y,
  input  logic [ugpb_pkg::PID_W-1:0]          in_particle_id,
  input  logic [ugpb_pkg::SEL_W-1:0]          in_slot_sel,
  input  ugpb_pkg::ugpb_cmd_t                 cmd,
  output ugpb_pkg::ugpb_stat_t                stat,
  output logic [ugpb_pkg::CELL_NUM_W-1:0]     out_cell_number,
  output logic [ugpb_pkg::COUNT_W-1:0]        out_cell_count,
  output logic [ugpb_pkg::SLOTV_W-1:0]        out_slot_value,
  output logic [ugpb_pkg::STATUS_W-1:0]       out_status
);

  localparam int POS_W  = ugpb_pkg::POS_W;
  localparam int DIM_W  = ugpb_pkg::DIM_W;
  localparam int CELL_W = ugpb_pkg::CELL_W;
  localparam int SLOT_W = ugpb_pkg::SLOT_W;
  localparam int CNT_W  = ugpb_pkg::CNT_W;
  localparam int ID_W   = ugpb_pkg::ID_BITS;
  localparam int IDX_W  = ugpb_pkg::IDX_W;
  localparam int PROD_W = ugpb_pkg::PROD_W;

  // configuration
  logic [POS_W-1:0] grid_min_x_r, grid_min_y_r, inv_cell_r;
  logic [DIM_W-1:0] cols_r, rows_r;

  // request
  logic [ugpb_pkg::OP_W-1:0]  op_r;
  logic [POS_W-1:0]           pos_x_r, pos_y_r;
  logic [ID_W-1:0]            id_r;
  logic [ugpb_pkg::SEL_W-1:0] sel_r;

  // coordinate arithmetic
  logic [POS_W-1:0]  diff_pos, diff_min;
  logic [POS_W:0]    diff, diff_negv;
  logic [POS_W-1:0]  mag_r;
  logic              mag_neg_r;
  logic [PROD_W-1:0] prod_r, prod_w;
  logic              prod_neg_r;
  logic [POS_W-1:0]  quot;
  logic [DIM_W-1:0]  nc, nr, n_sel;
  logic              below, above;
  logic [DIM_W-1:0]  cx_r, cy_r;
  logic              cx_lo_r, cx_hi_r, cy_lo_r, cy_hi_r;
  logic [DIM_W-1:0]  cxe, cye;
  logic [IDX_W-1:0]  idx;
  logic              oor, idx_big;
  logic [CELL_W-1:0] cell_r;
  logic              bad_r;

  // memories
  logic [CNT_W-1:0]         cnt_mem [ugpb_pkg::CELL_COUNT];
  logic [CNT_W-1:0]         cnt_q_r;
  logic                     cnt_we;
  logic [CELL_W-1:0]        cnt_waddr;
  logic [CNT_W-1:0]         cnt_wdata;
  logic                     full;
  logic [ID_W-1:0]          slot_mem [ugpb_pkg::CELL_COUNT * ugpb_pkg::SLOTS];
  logic [ID_W-1:0]          slot_q_r;
  logic [SLOT_W-1:0]        slot_ridx, slot_widx, last_idx, sel_idx;
  logic                     slot_we;
  logic [ID_W-1:0]          slot_wdata;
  logic [CELL_W-1:0]        sweep_addr_r;
  logic                     sweep_last;

  // scan
  logic [CNT_W-1:0]  scan_r;
  logic              pend_r;
  logic [SLOT_W-1:0] pidx_r, hit_idx_r;
  logic              scan_more, scan_hit, sel_hit;

  // result
  logic [ugpb_pkg::CELL_NUM_W-1:0] res_cell_r;
  logic [ugpb_pkg::COUNT_W-1:0]    res_cnt_r;
  logic [ugpb_pkg::SLOTV_W-1:0]    res_slot_r;
  logic [ugpb_pkg::STATUS_W-1:0]   res_status_r;
  logic [ugpb_pkg::CELL_NUM_W-1:0] out_cell_r;
  logic [ugpb_pkg::COUNT_W-1:0]    out_cnt_r;
  logic [ugpb_pkg::SLOTV_W-1:0]    out_slot_r;
  logic [ugpb_pkg::STATUS_W-1:0]   out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_min_x_r <= '0;
      grid_min_y_r <= '0;
      inv_cell_r   <= ugpb_pkg::INV_CELL_RESET;
      cols_r       <= ugpb_pkg::DIM_RESET;
      rows_r       <= ugpb_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ugpb_pkg::CFG_GRID_MIN_X: grid_min_x_r <= cfg_wdata;
        ugpb_pkg::CFG_GRID_MIN_Y: grid_min_y_r <= cfg_wdata;
        ugpb_pkg::CFG_INV_CELL:   inv_cell_r   <= cfg_wdata;
        ugpb_pkg::CFG_COLS:       cols_r       <= cfg_wdata[DIM_W-1:0];
        ugpb_pkg::CFG_ROWS:       rows_r       <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r    <= in_operation;
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      id_r    <= ID_W'(in_particle_id);
      sel_r   <= in_slot_sel;
    end
  end

  // pos - grid_min, then magnitude and sign
  assign diff_pos  = cmd.diff_y ? pos_y_r : pos_x_r;
  assign diff_min  = cmd.diff_y ? grid_min_y_r : grid_min_x_r;
  assign diff      = {diff_pos[POS_W-1], diff_pos} - {diff_min[POS_W-1], diff_min};
  assign diff_negv = (POS_W+1)'(0) - diff;
  assign prod_w    = PROD_W'(mag_r) * PROD_W'(inv_cell_r);

  always_ff @(posedge clk) begin
    if (cmd.diff_x || cmd.diff_y) begin
      mag_neg_r <= diff[POS_W];
      mag_r     <= diff[POS_W] ? diff_negv[POS_W-1:0] : diff[POS_W-1:0];
    end
    if (cmd.mul) begin
      prod_r     <= prod_w;
      prod_neg_r <= mag_neg_r;
    end
  end

  // floor of the signed product, reduced to below/above/in-range
  assign nc    = (cols_r == '0) ? DIM_W'(1) : cols_r;
  assign nr    = (rows_r == '0) ? DIM_W'(1) : rows_r;
  assign n_sel = cmd.take_y ? nr : nc;
  assign quot  = prod_r[PROD_W-1:POS_W];
  assign below = prod_neg_r && (prod_r != '0);
  assign above = !below && (quot >= POS_W'(n_sel));

  always_ff @(posedge clk) begin
    if (cmd.take_x) begin
      cx_r    <= quot[DIM_W-1:0];
      cx_lo_r <= below;
      cx_hi_r <= above;
    end
    if (cmd.take_y) begin
      cy_r    <= quot[DIM_W-1:0];
      cy_lo_r <= below;
      cy_hi_r <= above;
    end
  end

  assign cxe     = cx_lo_r ? '0 : (cx_hi_r ? nc - DIM_W'(1) : cx_r);
  assign cye     = cy_lo_r ? '0 : (cy_hi_r ? nr - DIM_W'(1) : cy_r);
  assign idx     = IDX_W'(cxe) + IDX_W'(cye) * IDX_W'(nc);
  assign oor     = cx_lo_r || cx_hi_r || cy_lo_r || cy_hi_r;
  assign idx_big = 32'(idx) >= 32'(ugpb_pkg::CELL_COUNT);

  always_ff @(posedge clk) begin
    if (cmd.cell_calc) begin
      cell_r <= CELL_W'(idx);
      bad_r  <= ((op_r == ugpb_pkg::OP_REGISTER) && oor) || idx_big;
    end
  end

  // count store
  assign full       = cnt_q_r >= CNT_W'(ugpb_pkg::SLOTS);
  assign sweep_last = sweep_addr_r == CELL_W'(ugpb_pkg::CELL_COUNT - 1);
  assign cnt_we     = cmd.sweep || (cmd.reg_wr && !full) || cmd.move_wr;
  assign cnt_waddr  = cmd.sweep ? sweep_addr_r : cell_r;
  assign cnt_wdata  = cmd.sweep ? '0 :
                      (cmd.move_wr ? cnt_q_r - CNT_W'(1) : cnt_q_r + CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_q_r <= cnt_mem[cell_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_addr_r <= '0;
    end else if (cmd.sweep) begin
      sweep_addr_r <= sweep_last ? '0 : sweep_addr_r + CELL_W'(1);
    end
  end

  // slot store
  assign last_idx   = SLOT_W'(cnt_q_r - CNT_W'(1));
  assign sel_idx    = SLOT_W'(sel_r);
  assign slot_ridx  = cmd.scan_step ? SLOT_W'(scan_r) : (cmd.last_rd ? last_idx : sel_idx);
  assign slot_we    = (cmd.reg_wr && !full) || cmd.move_wr;
  assign slot_widx  = cmd.move_wr ? hit_idx_r : SLOT_W'(cnt_q_r);
  assign slot_wdata = cmd.move_wr ? slot_q_r : id_r;

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[{cell_r, slot_widx}] <= slot_wdata;
    slot_q_r <= slot_mem[{cell_r, slot_ridx}];
  end

  // handle search, one slot read issued per cycle, compared in the cycle after
  assign scan_more = (scan_r < cnt_q_r) && (scan_r < CNT_W'(ugpb_pkg::SLOTS));
  assign scan_hit  = pend_r && (slot_q_r == id_r);
  assign sel_hit   = (32'(sel_r) < 32'(cnt_q_r)) && (32'(sel_r) < 32'(ugpb_pkg::SLOTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
      pend_r <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_r <= '0;
      pend_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (scan_more) begin
        pidx_r <= SLOT_W'(scan_r);
        pend_r <= 1'b1;
        scan_r <= scan_r + CNT_W'(1);
      end else begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.last_rd) hit_idx_r <= pidx_r;
  end

  // result
  always_ff @(posedge clk) begin
    case (cmd.res)
      ugpb_pkg::RES_BAD: begin
        res_cell_r   <= '0;
        res_cnt_r    <= '0;
        res_slot_r   <= '0;
        res_status_r <= ugpb_pkg::ST_OOR;
      end
      ugpb_pkg::RES_CLEAR: begin
        res_cell_r   <= '0;
        res_cnt_r    <= '0;
        res_slot_r   <= '0;
        res_status_r <= ugpb_pkg::ST_OK;
      end
      ugpb_pkg::RES_REG: begin
        res_cell_r   <= ugpb_pkg::CELL_NUM_W'(cell_r);
        res_cnt_r    <= full ? ugpb_pkg::COUNT_W'(cnt_q_r)
                             : ugpb_pkg::COUNT_W'(cnt_q_r + CNT_W'(1));
        res_slot_r   <= '0;
        res_status_r <= full ? ugpb_pkg::ST_FULL : ugpb_pkg::ST_OK;
      end
      ugpb_pkg::RES_READ: begin
        res_cell_r   <= ugpb_pkg::CELL_NUM_W'(cell_r);
        res_cnt_r    <= ugpb_pkg::COUNT_W'(cnt_q_r);
        res_slot_r   <= sel_hit ? ugpb_pkg::SLOTV_W'(slot_q_r) : '0;
        res_status_r <= ugpb_pkg::ST_OK;
      end
      ugpb_pkg::RES_NF: begin
        res_cell_r   <= ugpb_pkg::CELL_NUM_W'(cell_r);
        res_cnt_r    <= ugpb_pkg::COUNT_W'(cnt_q_r);
        res_slot_r   <= '0;
        res_status_r <= ugpb_pkg::ST_NOT_FOUND;
      end
      ugpb_pkg::RES_UNREG: begin
        res_cell_r   <= ugpb_pkg::CELL_NUM_W'(cell_r);
        res_cnt_r    <= ugpb_pkg::COUNT_W'(cnt_q_r - CNT_W'(1));
        res_slot_r   <= '0;
        res_status_r <= ugpb_pkg::ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cell_r   <= res_cell_r;
      out_cnt_r    <= res_cnt_r;
      out_slot_r   <= res_slot_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_cell_number = out_cell_r;
  assign out_cell_count  = out_cnt_r;
  assign out_slot_value  = out_slot_r;
  assign out_status      = out_status_r;

  assign stat.op         = op_r;
  assign stat.bad        = bad_r;
  assign stat.scan_hit   = scan_hit;
  assign stat.scan_done  = !pend_r && !scan_more;
  assign stat.sweep_last = sweep_last;

endmodule

// ----- design/uniform_grid_particle_binning_unit.sv -----
// Uniform grid particle binning unit, top level: one request in flight at a time.
// Unregister searches the cell's slots in order, one slot compared per cycle.
// The next request is taken in the cycle after its result is loaded into the output register.
// After reset a sweep zeroes the count store before requests are
// taken; configuration writes are taken at any time. The slot store is not initialized.
module uniform_grid_particle_binning_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  ugpb_in_if.sink                               in_ch,
  ugpb_out_if.source                            out_ch,
  input  logic                                  cfg_we,
  input  logic [ugpb_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ugpb_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  ugpb_pkg::ugpb_cmd_t  cmd;
  ugpb_pkg::ugpb_stat_t stat;

  ugpb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ugpb_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_operation    (in_ch.operation),
    .in_pos_x        (in_ch.pos_x),
    .in_pos_y        (in_ch.pos_y),
    .in_particle_id  (in_ch.particle_id),
    .in_slot_sel     (in_ch.slot_sel),
    .cmd             (cmd),
    .stat            (stat),
    .out_cell_number (out_ch.cell_number),
    .out_cell_count  (out_ch.cell_count),
    .out_slot_value  (out_ch.slot_value),
    .out_status      (out_ch.status)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while another is in flight");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ugpb_pkg::ST_OOR)
      |-> (out_ch.cell_number == '0 && out_ch.cell_count == '0))
    else $error("out of range result carries a cell");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (32'(out_ch.cell_count) <= ugpb_pkg::SLOTS))
    else $error("cell count beyond slot capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ugpb_pkg::ST_FULL)
      |-> (32'(out_ch.cell_count) == ugpb_pkg::SLOTS))
    else $error("cell full reported with spare slots");

endmodule

// ----- sim/tb.sv -----
// Testbench for the uniform grid particle binning unit: directed and random requests,
// each result checked against a grid model kept in a small scoreboard class.
// Depends on ugpb_pkg, ugpb_in_if, ugpb_out_if and uniform_grid_particle_binning_unit.
import ugpb_pkg::*;

typedef struct packed {
  logic [OP_W-1:0]  op;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [PID_W-1:0] particle_id;
  logic [SEL_W-1:0] slot_sel;
} bin_req_t;

typedef struct packed {
  logic [CELL_NUM_W-1:0] cell_number;
  logic [COUNT_W-1:0]    cell_count;
  logic [SLOTV_W-1:0]    slot_value;
  logic [STATUS_W-1:0]   status;
} bin_result_t;

class grid_bin_tracker;
  logic [POS_W-1:0]   min_x;
  logic [POS_W-1:0]   min_y;
  logic [POS_W-1:0]   inv_cell;
  logic [DIM_W-1:0]   n_cols;
  logic [DIM_W-1:0]   n_rows;
  logic [COUNT_W-1:0] counts [CELL_COUNT];
  logic [PID_W-1:0]   handles [CELL_COUNT*SLOTS];
  bin_result_t        expected_bins [$];
  int                 mismatches;
  int                 results_seen;

  function new();
    min_x = '0;
    min_y = '0;
    inv_cell = INV_CELL_RESET;
    n_cols = DIM_RESET;
    n_rows = DIM_RESET;
    foreach (counts[k]) counts[k] = '0;
    foreach (handles[k]) handles[k] = '0;
    mismatches = 0;
    results_seen = 0;
  endfunction

  function void set_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_GRID_MIN_X: min_x = data;
      CFG_GRID_MIN_Y: min_y = data;
      CFG_INV_CELL:   inv_cell = data;
      CFG_COLS:       n_cols = data[DIM_W-1:0];
      CFG_ROWS:       n_rows = data[DIM_W-1:0];
      default: ;
    endcase
  endfunction

  // floor((pos - lo) * inv_cell) with exact Q32.32 product
  function longint floor_coord(logic [POS_W-1:0] pos, logic [POS_W-1:0] lo);
    longint          diff;
    longint unsigned mag;
    longint unsigned prod;
    longint          q;
    diff = longint'($signed(pos)) - longint'($signed(lo));
    mag = (diff < 0) ? -diff : diff;
    prod = mag * inv_cell;
    q = longint'(prod >> 32);
    if (diff >= 0) return q;
    return -q - ((prod[31:0] != 0) ? 1 : 0);
  endfunction

  // -1 marks a cell outside the grid or beyond the store
  function int locate_bin(logic [OP_W-1:0] op, logic [POS_W-1:0] px,
                          logic [POS_W-1:0] py);
    longint cx;
    longint cy;
    longint nc;
    longint nr;
    longint idx;
    nc = (n_cols == 0) ? 1 : n_cols;
    nr = (n_rows == 0) ? 1 : n_rows;
    cx = floor_coord(px, min_x);
    cy = floor_coord(py, min_y);
    if (op == OP_REGISTER) begin
      if (cx < 0 || cy < 0 || cx >= nc || cy >= nr) return -1;
    end else begin
      if (cx < 0) cx = 0;
      else if (cx >= nc) cx = nc - 1;
      if (cy < 0) cy = 0;
      else if (cy >= nr) cy = nr - 1;
    end
    idx = cx + cy * nc;
    if (idx >= CELL_COUNT) return -1;
    return int'(idx);
  endfunction

  function void note_request(bin_req_t r);
    bin_result_t e;
    int          bin_id;
    int          c;
    int          base;
    int          i;
    e = '0;
    if (r.op == OP_CLEAR) begin
      foreach (counts[k]) counts[k] = '0;
    end else begin
      bin_id = locate_bin(r.op, r.pos_x, r.pos_y);
      if (bin_id < 0) begin
        e.status = ST_OOR;
      end else begin
        c = counts[bin_id];
        base = bin_id * SLOTS;
        e.cell_number = CELL_NUM_W'(bin_id);
        case (r.op)
          OP_REGISTER: begin
            if (c >= SLOTS) begin
              e.status = ST_FULL;
            end else begin
              handles[base + c] = r.particle_id;
              c = c + 1;
              counts[bin_id] = COUNT_W'(c);
            end
          end
          OP_UNREGISTER: begin
            e.status = ST_NOT_FOUND;
            for (i = 0; i < c; i++) begin
              if (e.status == ST_NOT_FOUND && handles[base + i] == r.particle_id) begin
                handles[base + i] = handles[base + c - 1];
                e.status = ST_OK;
              end
            end
            if (e.status == ST_OK) begin
              c = c - 1;
              counts[bin_id] = COUNT_W'(c);
            end
          end
          default: begin
            if (r.slot_sel < c) e.slot_value = handles[base + r.slot_sel];
          end
        endcase
        e.cell_count = COUNT_W'(c);
      end
    end
    expected_bins.push_back(e);
  endfunction

  function void check_result(bin_result_t got);
    bin_result_t want;
    results_seen++;
    if (expected_bins.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: cell %0d count %0d slot %h status %0d",
                 got.cell_number, got.cell_count, got.slot_value, got.status);
      return;
    end
    want = expected_bins.pop_front();
    if (got.cell_number !== want.cell_number || got.cell_count !== want.cell_count ||
        got.slot_value !== want.slot_value || got.status !== want.status) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"result mismatch: expected cell %0d count %0d slot %h status %0d,",
                  " got cell %0d count %0d slot %h status %0d"},
                 want.cell_number, want.cell_count, want.slot_value, want.status,
                 got.cell_number, got.cell_count, got.slot_value, got.status);
    end
  endfunction

  // pick a handle currently held in the (clamped) cell, if any
  function logic [PID_W-1:0] pick_handle(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
    int bin_id;
    bin_id = locate_bin(OP_UNREGISTER, px, py);
    if (bin_id < 0 || counts[bin_id] == 0) return PID_W'($urandom_range(0, 15));
    return handles[bin_id * SLOTS + $urandom_range(0, counts[bin_id] - 1)];
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int HOLD_CYCLES = 600;
  localparam int N_PHASES    = 8;

  typedef struct {
    logic [POS_W-1:0] min_x;
    logic [POS_W-1:0] min_y;
    logic [POS_W-1:0] inv;
    int               cols;
    int               rows;
    int               shift;
    int               items;
  } grid_phase_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ugpb_in_if  in_ch ();
  ugpb_out_if out_ch ();

  grid_bin_tracker tracker;
  grid_phase_t     phases [N_PHASES];
  int              cycle_count;
  bit              held_off;

  uniform_grid_particle_binning_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      tracker.note_request('{in_ch.operation, in_ch.pos_x, in_ch.pos_y,
                             in_ch.particle_id, in_ch.slot_sel});
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_result('{out_ch.cell_number, out_ch.cell_count,
                             out_ch.slot_value, out_ch.status});
  end

  initial begin
    rx_mode_t mode;
    int       seg_len;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held_off && tracker.results_seen >= 40) begin
        held_off = 1'b1;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_ch.ready = 1'b0;
        end
      end
      seg_len = $urandom_range(10, 150);
      mode = rx_mode_t'($urandom_range(0, 3));
      repeat (seg_len) begin
        @(negedge clk);
        case (mode)
          RX_OPEN:   out_ch.ready = 1'b1;
          RX_COIN:   out_ch.ready = $urandom_range(0, 1);
          RX_SPARSE: out_ch.ready = ($urandom_range(0, 5) == 0);
          default:   out_ch.ready = ~out_ch.ready;
        endcase
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic drive_request(bin_req_t r);
    in_ch.valid       = 1'b1;
    in_ch.operation   = r.op;
    in_ch.pos_x       = r.pos_x;
    in_ch.pos_y       = r.pos_y;
    in_ch.particle_id = r.particle_id;
    in_ch.slot_sel    = r.slot_sel;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic issue_request(logic [OP_W-1:0] op, logic [POS_W-1:0] px,
                               logic [POS_W-1:0] py, logic [PID_W-1:0] id,
                               logic [SEL_W-1:0] sel);
    @(negedge clk);
    drive_request('{op, px, py, id, sel});
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (tracker.expected_bins.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    tracker.set_cfg(idx, data);
  endtask

  task automatic load_grid(grid_phase_t g);
    write_reg(CFG_GRID_MIN_X, g.min_x);
    write_reg(CFG_GRID_MIN_Y, g.min_y);
    write_reg(CFG_INV_CELL, g.inv);
    write_reg(CFG_COLS, CFG_DATA_W'(g.cols));
    write_reg(CFG_ROWS, CFG_DATA_W'(g.rows));
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // position that mostly lands in a chosen cell, sometimes just outside the grid
  function automatic logic [POS_W-1:0] axis_pos(logic [POS_W-1:0] lo, int shift, int n);
    longint c;
    longint span;
    longint off;
    int     pick;
    if (shift >= 32) return $urandom;
    span = 64'sd1 <<< shift;
    pick = $urandom_range(0, 9);
    if (pick == 0) c = -longint'($urandom_range(1, 3));
    else if (pick == 1) c = n + $urandom_range(0, 2);
    else if (pick < 6) c = $urandom_range(0, (n < 4) ? n - 1 : 3);
    else c = $urandom_range(0, n - 1);
    off = c * span + longint'({32'd0, $urandom} & (span - 1));
    return lo + POS_W'(off);
  endfunction

  function automatic bin_req_t make_request(grid_phase_t g);
    bin_req_t r;
    int       roll;
    int       nc;
    int       nr;
    nc = (g.cols == 0) ? 1 : g.cols;
    nr = (g.rows == 0) ? 1 : g.rows;
    roll = $urandom_range(0, 99);
    if (roll < 3) r.op = OP_CLEAR;
    else if (roll < 48) r.op = OP_REGISTER;
    else if (roll < 73) r.op = OP_UNREGISTER;
    else r.op = OP_READ;
    if ($urandom_range(0, 11) == 0) begin
      r.pos_x = $urandom;
      r.pos_y = $urandom;
    end else begin
      r.pos_x = axis_pos(g.min_x, g.shift, nc);
      r.pos_y = axis_pos(g.min_y, g.shift, nr);
    end
    if (r.op == OP_UNREGISTER && $urandom_range(0, 3) != 0)
      r.particle_id = tracker.pick_handle(r.pos_x, r.pos_y);
    else if ($urandom_range(0, 1) == 0)
      r.particle_id = PID_W'($urandom_range(0, 15));
    else
      r.particle_id = PID_W'($urandom);
    r.slot_sel = SEL_W'($urandom_range(0, SLOTS - 1));
    return r;
  endfunction

  initial begin
    bin_req_t req;
    int       burst_left;
    int       gap;
    int       p;
    int       k;
    tracker = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_REGISTER;
    in_ch.pos_x       = '0;
    in_ch.pos_y       = '0;
    in_ch.particle_id = '0;
    in_ch.slot_sel    = '0;

    phases[0] = '{32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 4, 3, 16, 220};
    phases[1] = '{32'hFFFB_0000, 32'h0003_4000, 32'h0010_0000, 8, 2, 12, 200};
    phases[2] = '{32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 0, 0, 32, 80};
    phases[3] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 64, 64, 0, 80};
    phases[4] = '{32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 127, 127, 16, 180};
    phases[5] = '{32'h03E8_8000, 32'hFF38_0000, 32'h0000_4000, 1, 64, 18, 200};
    phases[6] = '{32'h1357_9BDF, 32'hECA8_6420, 32'h0000_0000, 3, 3, 32, 60};
    phases[7] = '{32'h0012_3456, 32'hFFF0_0000, 32'h0001_2345, 5, 7, 16, 330};

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    issue_request(OP_REGISTER, 32'h0000_0000, 32'h0000_0000, 16'h0000, 4'h0);
    for (k = 0; k < SLOTS; k++)
      issue_request(OP_REGISTER, 32'h003F_FFFF, 32'h003F_FFFF,
                    16'hFFFF - PID_W'(k) * 16'h1111, 4'hF);
    issue_request(OP_REGISTER, 32'h003F_FFFF, 32'h003F_FFFF, 16'h1234, 4'h0);
    issue_request(OP_REGISTER, 32'h8000_0000, 32'h0000_0000, 16'h5555, 4'h0);
    issue_request(OP_REGISTER, 32'h0000_0000, 32'h7FFF_FFFF, 16'hAAAA, 4'h0);
    issue_request(OP_READ, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000, 4'hF);
    issue_request(OP_READ, 32'h0000_0000, 32'h0000_0000, 16'h0000, 4'h3);
    issue_request(OP_UNREGISTER, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hDDDD, 4'h0);
    issue_request(OP_UNREGISTER, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hDDDD, 4'h0);
    issue_request(OP_READ, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000, 4'h2);
    issue_request(OP_UNREGISTER, 32'h8000_0000, 32'h8000_0000, 16'h0000, 4'h0);
    issue_request(OP_CLEAR, 32'h0000_0000, 32'h0000_0000, 16'h0000, 4'h0);
    issue_request(OP_READ, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000, 4'h0);
    wait_for_results();

    burst_left = 0;
    for (p = 0; p < N_PHASES; p++) begin
      load_grid(phases[p]);
      for (k = 0; k < phases[p].items; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          if (gap > 0) begin
            @(negedge clk);
            in_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
          end
        end
        @(negedge clk);
        req = make_request(phases[p]);
        drive_request(req);
        burst_left--;
      end
      wait_for_results();
    end

    repeat (60) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.expected_bins.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
